[src/indexed_array_stack_bag_macros.svh]
// assertion helpers for the stack and bag block
`ifndef INDEXED_ARRAY_STACK_BAG_MACROS_SVH
`define INDEXED_ARRAY_STACK_BAG_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, ignored while reset is held
`define IASB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iasb check failed");

// next-cycle implication, ignored while reset is held
`define IASB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iasb check failed");

`else

`define IASB_ASSERT_NOW(lbl, ante, cons)
`define IASB_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[src/iasb_pkg.sv]
package iasb_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int DATA_W = 32;
  localparam int IN_W   = 56;
  localparam int OUT_W  = 64;

  typedef enum logic [3:0] {
    OP_APPEND     = 4'd0,
    OP_READ       = 4'd1,
    OP_WRITE      = 4'd2,
    OP_SWAP       = 4'd3,
    OP_REMOVE_AT  = 4'd4,
    OP_POP        = 4'd5,
    OP_TOP        = 4'd6,
    OP_CONTAINS   = 4'd7,
    OP_REMOVE_VAL = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_RANGE   = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [9:0]         second_index;
    logic [9:0]         index;
    logic [3:0]         operation;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic               is_empty;
    logic [10:0]        element_count;
    logic [9:0]         found_position;
    logic signed [31:0] read_value;
  } res_t;

endpackage

[src/iasb_ram.sv]
module iasb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/iasb_ctrl.sv]
module iasb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  iasb_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output iasb_pkg::res_t res
);

  import iasb_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EXEC    = 9'b000000010,
    S_RDWAIT  = 9'b000000100,
    S_SWAP_B  = 9'b000001000,
    S_SWAP_WA = 9'b000010000,
    S_SWAP_WB = 9'b000100000,
    S_SHIFT   = 9'b001000000,
    S_SCAN    = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0]        op_r, op_nxt;
  logic [ADDR_W-1:0] a_r, a_nxt;
  logic [ADDR_W-1:0] b_r, b_nxt;
  logic [DATA_W-1:0] d_r, d_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] tag_r, tag_nxt;
  logic [DATA_W-1:0] tmp_r, tmp_nxt;
  logic [DATA_W-1:0] rv_r, rv_nxt;
  logic [ADDR_W-1:0] fp_r, fp_nxt;
  status_t           st_r, st_nxt;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rd_data;
  logic              a_bad, b_bad, more, hit;

  iasb_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign a_bad = {1'b0, a_r} >= count_r;
  assign b_bad = {1'b0, b_r} >= count_r;
  // walk pointer still below the count
  assign more  = rd_idx_r < count_r;
  assign hit   = pend_r && (rd_data == d_r);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    d_nxt      = d_r;
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    pend_nxt   = pend_r;
    tag_nxt    = tag_r;
    tmp_nxt    = tmp_r;
    rv_nxt     = rv_r;
    fp_nxt     = fp_r;
    st_nxt     = st_r;
    wr_en      = 1'b0;
    wr_addr    = a_r;
    wr_data    = d_r;
    rd_en      = 1'b0;
    rd_addr    = a_r;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt    = req.operation;
          a_nxt     = req.index;
          b_nxt     = req.second_index;
          d_nxt     = req.value;
          rv_nxt    = '0;
          fp_nxt    = '0;
          st_nxt    = ST_OK;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        if (op_r == OP_APPEND) begin
          if (count_r == CNT_W'(DEPTH)) begin
            st_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = count_r[ADDR_W-1:0];
            count_nxt = count_r + 1'b1;
          end
        end else if (op_r > OP_REMOVE_VAL) begin
          st_nxt = ST_OK;
        end else if (count_r == '0) begin
          st_nxt = ST_EMPTY;
        end else begin
          unique case (op_r)
            OP_READ: begin
              if (a_bad) begin
                st_nxt = ST_RANGE;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_RDWAIT;
              end
            end
            OP_WRITE: begin
              if (a_bad) begin
                st_nxt = ST_RANGE;
              end else begin
                wr_en = 1'b1;
              end
            end
            OP_SWAP: begin
              if (a_bad || b_bad) begin
                st_nxt = ST_RANGE;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_SWAP_B;
              end
            end
            OP_REMOVE_AT: begin
              if (a_bad) begin
                st_nxt = ST_RANGE;
              end else begin
                rd_idx_nxt = {1'b0, a_r} + 1'b1;
                pend_nxt   = 1'b0;
                state_nxt  = S_SHIFT;
              end
            end
            OP_POP: begin
              count_nxt = count_r - 1'b1;
            end
            OP_TOP: begin
              rd_en     = 1'b1;
              rd_addr   = ADDR_W'(count_r - 1'b1);
              state_nxt = S_RDWAIT;
            end
            OP_CONTAINS, OP_REMOVE_VAL: begin
              rd_idx_nxt = '0;
              pend_nxt   = 1'b0;
              state_nxt  = S_SCAN;
            end
            default: begin
              st_nxt = ST_OK;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        rv_nxt    = rd_data;
        state_nxt = S_DONE;
      end
      S_SWAP_B: begin
        tmp_nxt   = rd_data;
        rd_en     = 1'b1;
        rd_addr   = b_r;
        state_nxt = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        wr_en     = 1'b1;
        wr_data   = rd_data;
        state_nxt = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        wr_en     = 1'b1;
        wr_addr   = b_r;
        wr_data   = tmp_r;
        state_nxt = S_DONE;
      end
      S_SHIFT: begin
        // read one above, write it one below in the next cycle
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = tag_r;
          wr_data = rd_data;
        end
        if (more) begin
          rd_en      = 1'b1;
          rd_addr    = rd_idx_r[ADDR_W-1:0];
          pend_nxt   = 1'b1;
          tag_nxt    = ADDR_W'(rd_idx_r - 1'b1);
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          fp_nxt = tag_r;
          if (op_r == OP_REMOVE_VAL) begin
            rd_idx_nxt = {1'b0, tag_r} + 1'b1;
            pend_nxt   = 1'b0;
            state_nxt  = S_SHIFT;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (more) begin
          rd_en      = 1'b1;
          rd_addr    = rd_idx_r[ADDR_W-1:0];
          pend_nxt   = 1'b1;
          tag_nxt    = rd_idx_r[ADDR_W-1:0];
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else if (!pend_r) begin
          st_nxt    = ST_MISSING;
          state_nxt = S_DONE;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    d_r      <= d_nxt;
    rd_idx_r <= rd_idx_nxt;
    tag_r    <= tag_nxt;
    tmp_r    <= tmp_nxt;
    rv_r     <= rv_nxt;
    fp_r     <= fp_nxt;
    st_r     <= st_nxt;
  end

  assign req_ready          = state_r == S_IDLE;
  assign res_valid          = state_r == S_DONE;
  assign res.read_value     = rv_r;
  assign res.found_position = fp_r;
  assign res.element_count  = count_r;
  assign res.is_empty       = count_r == '0;
  assign res.status         = st_r;

endmodule

[src/indexed_array_stack_bag.sv]
// one transaction at a time; in_tready drops from acceptance until the result moves to out_tdata
// append, write, pop and bad requests finish in the execute state; read and top add a read wait;
// swap reads both entries, then writes both back; remove at shifts the entries above index down;
// contains scans from the first entry; remove value scans then shifts down; the store port does
// one read and one write a cycle
// rst_n clears the count and handshake state only; the element store is not cleared
module indexed_array_stack_bag (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // operation, index, second_index, value (lowest bit first)
  input  logic [iasb_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // read_value, found_position, element_count, is_empty, status (lowest bit first)
  output logic [iasb_pkg::OUT_W-1:0] out_tdata
);

  import iasb_pkg::*;

  `include "indexed_array_stack_bag_macros.svh"

  req_t             req;
  res_t             res;
  logic             res_valid, res_ready;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  assign req = req_t'(in_tdata[IN_W-1:0]);

  iasb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register frees the sequencer while the result waits downstream
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_W'(res);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `IASB_ASSERT_NEXT(busy_after_accept, in_tvalid && in_tready, !in_tready)
  `IASB_ASSERT_NOW(empty_flag_matches, out_tvalid, out_tdata[53] == (out_tdata[52:42] == 11'd0))
  `IASB_ASSERT_NOW(count_in_bounds, out_tvalid, out_tdata[52:42] <= 11'(DEPTH))

endmodule
